@@ rtl/spq_pkg.sv @@
// shared types and constants of the sorted priority queue
package spq_pkg;

  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int COUNT_FIELD_W = 7;

  // input item action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } spq_status_e;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } spq_op_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } spq_entry_t;

  typedef struct packed {
    spq_op_e    op;
    spq_entry_t entry;
  } spq_cmd_t;

  typedef struct packed {
    logic                     action;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_priority;
  } spq_in_t;

  typedef struct packed {
    spq_status_e              status;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] head_priority;
    logic                     queue_empty;
    logic [COUNT_FIELD_W-1:0] entry_count;
  } spq_out_t;

endpackage

@@ rtl/spq_cell.sv @@
// one slot of the sorted row: holds, takes the new entry, or shifts from a neighbor
module spq_cell import spq_pkg::*; (
  input  logic       clk_i,
  input  spq_cmd_t   cmd_i,
  input  logic       occupied_i,
  input  logic       left_keep_i,
  input  spq_entry_t left_entry_i,
  input  spq_entry_t right_entry_i,
  output logic       keep_o,
  output spq_entry_t entry_o,
  output spq_entry_t entry_d_o
);

  spq_entry_t entry_q, entry_d;

  // an occupied slot whose priority is not below the new one stays put on insert
  assign keep_o = occupied_i && !(entry_q.prio < cmd_i.entry.prio);

  // next slot content
  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (keep_o) begin
          entry_d = entry_q;
        end else if (left_keep_i) begin
          entry_d = cmd_i.entry;
        end else begin
          entry_d = left_entry_i;
        end
      end
      OP_REMOVE: entry_d = right_entry_i;
      OP_HOLD:   entry_d = entry_q;
      default:   entry_d = entry_q;
    endcase
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

@@ rtl/sorted_priority_queue.sv @@
// top level of the sorted priority queue: cell row, count and result register
// Sorted priority queue of DEPTH entries held in a row of cells, highest
// priority at cell 0, equal priorities in arrival order. Each input item
// inserts or removes the head and yields one result item with the status,
// the new head and the entry count. One item is taken per cycle and its
// result is registered: all cells update in parallel, each cell doing one
// 32-bit priority compare against the new entry and a shift from a
// neighbor. Input stalls only while a result waits untaken at the output.
module sorted_priority_queue import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  spq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output spq_out_t out_data_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  spq_out_t         out_data_q, out_data_d;

  spq_cmd_t    cmd;
  spq_status_e status;
  logic        in_fire;
  logic        full, empty;

  logic       occupied [DEPTH];
  logic       keep     [DEPTH];
  spq_entry_t entry    [DEPTH];
  spq_entry_t entry_d  [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);

  // decode the item into a row command, count and status
  always_comb begin
    cmd.op          = OP_HOLD;
    cmd.entry.value = in_data_i.item_value;
    cmd.entry.prio  = in_data_i.item_priority;
    status  = ST_OK;
    count_d = count_q;
    if (in_fire) begin
      if (in_data_i.action == ACT_INSERT) begin
        if (full) begin
          status = ST_OVERFLOW;
        end else begin
          cmd.op  = OP_INSERT;
          count_d = count_q + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          status = ST_UNDERFLOW;
        end else begin
          cmd.op  = OP_REMOVE;
          count_d = count_q - CNT_W'(1);
        end
      end
    end
  end

  // row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    spq_entry_t left_entry, right_entry;
    logic       left_keep;

    assign occupied[g] = (count_q > CNT_W'(g));

    if (g == 0) begin : g_first
      assign left_keep  = 1'b1;
      assign left_entry = cmd.entry;
    end else begin : g_inner
      assign left_keep  = keep[g-1];
      assign left_entry = entry[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_entry = entry[g];
    end else begin : g_mid
      assign right_entry = entry[g+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occupied_i    (occupied[g]),
      .left_keep_i   (left_keep),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .keep_o        (keep[g]),
      .entry_o       (entry[g]),
      .entry_d_o     (entry_d[g])
    );
  end

  // result item from the state after the step
  always_comb begin
    out_data_d.status      = status;
    out_data_d.queue_empty = (count_d == '0);
    out_data_d.entry_count = COUNT_FIELD_W'(count_d);
    if (count_d == '0) begin
      out_data_d.head_value    = '0;
      out_data_d.head_priority = '0;
    end else begin
      out_data_d.head_value    = entry_d[0].value;
      out_data_d.head_priority = entry_d[0].prio;
    end
  end

  // output handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // count never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // an overflow is reported only with a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_OVERFLOW |->
      out_data_o.entry_count == COUNT_FIELD_W'(DEPTH))
    else $error("overflow reported on a queue that is not full");

  // an underflow leaves the queue empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_UNDERFLOW |-> out_data_o.queue_empty)
    else $error("underflow reported on a queue that is not empty");

  // an empty result carries a zero head and zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.queue_empty |->
      out_data_o.head_value == '0 && out_data_o.head_priority == '0 &&
      out_data_o.entry_count == '0)
    else $error("empty result with nonzero head or count");
`endif

endmodule

@@ verif/tb.sv @@
// self-checking testbench of the sorted priority queue
module tb;
  import spq_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  spq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  spq_out_t out_data;

  sorted_priority_queue uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the sorted entries
  logic signed [DATA_W-1:0] shadow_value [DEPTH];
  logic signed [DATA_W-1:0] shadow_prio [DEPTH];
  int unsigned              shadow_cnt = 0;

  spq_in_t  pending_q [$];
  spq_out_t snapshot_q [$];
  int       gen_cnt = 0;
  int       idle_cnt = 0;
  int       stall_cnt = 0;
  bit       send_calm = 1'b0;
  bit       recv_calm = 1'b0;
  int       mismatch_cnt = 0;
  int       result_idx = 0;

  // apply one item to the shadow queue and return the queue snapshot after it
  function automatic spq_out_t next_snapshot(spq_in_t it);
    spq_out_t    snap;
    int unsigned pos;
    snap = '0;
    snap.status = ST_OK;
    if (it.action == ACT_INSERT) begin
      if (shadow_cnt >= DEPTH) begin
        snap.status = ST_OVERFLOW;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = shadow_cnt;
        while (pos > 0 && $signed(shadow_prio[pos-1]) < $signed(it.item_priority)) begin
          shadow_value[pos] = shadow_value[pos-1];
          shadow_prio[pos]  = shadow_prio[pos-1];
          pos--;
        end
        shadow_value[pos] = it.item_value;
        shadow_prio[pos]  = it.item_priority;
        shadow_cnt++;
      end
    end else begin
      if (shadow_cnt == 0) begin
        snap.status = ST_UNDERFLOW;
      end else begin
        for (int j = 0; j + 1 < shadow_cnt; j++) begin
          shadow_value[j] = shadow_value[j+1];
          shadow_prio[j]  = shadow_prio[j+1];
        end
        shadow_cnt--;
      end
    end
    if (shadow_cnt == 0) begin
      snap.queue_empty = 1'b1;
    end else begin
      snap.head_value    = shadow_value[0];
      snap.head_priority = shadow_prio[0];
    end
    snap.entry_count = COUNT_FIELD_W'(shadow_cnt);
    return snap;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // priorities: clustered to force ties, extremes, or anything
  function automatic logic [DATA_W-1:0] rand_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return DATA_W'($signed($urandom_range(0, 7)) - 3);
    if (r < 50) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  task automatic add_item(logic act, logic [DATA_W-1:0] val, logic [DATA_W-1:0] prio);
    spq_in_t it;
    it.action        = act;
    it.item_value    = val;
    it.item_priority = prio;
    pending_q.push_back(it);
    if (act == ACT_INSERT && gen_cnt < DEPTH) gen_cnt++;
    if (act == ACT_REMOVE && gen_cnt > 0) gen_cnt--;
  endtask

  task automatic add_random(int insert_pct);
    if ($urandom_range(0, 99) < insert_pct) add_item(ACT_INSERT, $urandom(), rand_prio());
    else add_item(ACT_REMOVE, $urandom(), $urandom());
  endtask

  task automatic note_field(string fld, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("result %0d: %s expected %0h got %0h", result_idx, fld, want, got);
    end
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    spq_in_t data_n;
    logic    valid_n;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      data_n  = in_data;
      valid_n = in_valid;
      if (in_valid && in_ready) begin
        snapshot_q.push_back(next_snapshot(in_data));
        valid_n = 1'b0;
        if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
        idle_cnt = send_calm ? 0 : idle_len();
      end
      if (!valid_n) begin
        if (idle_cnt > 0) begin
          idle_cnt--;
        end else if (pending_q.size() > 0) begin
          data_n  = pending_q.pop_front();
          valid_n = 1'b1;
        end
      end
      in_valid <= valid_n;
      in_data  <= data_n;
    end
  end

  // result monitor and output stalls
  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    spq_out_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (snapshot_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("result %0d: no result expected", result_idx);
        end else begin
          want = snapshot_q.pop_front();
          note_field("status", DATA_W'(want.status), DATA_W'(out_data.status));
          note_field("head_value", want.head_value, out_data.head_value);
          note_field("head_priority", want.head_priority, out_data.head_priority);
          note_field("queue_empty", DATA_W'(want.queue_empty), DATA_W'(out_data.queue_empty));
          note_field("entry_count", DATA_W'(want.entry_count), DATA_W'(out_data.entry_count));
        end
        result_idx++;
      end
      if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
      if (stall_cnt == 0 && !recv_calm && $urandom_range(0, 3) == 0) stall_cnt = idle_len();
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int kind;
    int len;
    // remove on an empty queue
    add_item(ACT_REMOVE, 32'h1234_5678, 32'h7FFF_FFFF);
    // extreme values and priorities
    add_item(ACT_INSERT, 32'h8000_0000, 32'h0000_0000);
    add_item(ACT_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_item(ACT_INSERT, 32'hFFFF_FFFF, 32'h8000_0000);
    // ties with priority zero keep arrival order
    add_item(ACT_INSERT, 32'h0000_0000, 32'h0000_0000);
    add_item(ACT_INSERT, 32'h0000_0005, 32'h0000_0000);
    add_item(ACT_INSERT, 32'h5555_5555, 32'hFFFF_FFFF);
    add_item(ACT_INSERT, 32'hAAAA_AAAA, 32'h0000_0001);
    add_item(ACT_INSERT, 32'h0000_0009, 32'h7FFF_FFFF);
    // drain past empty, remove fields carry junk
    repeat (9) add_item(ACT_REMOVE, $urandom(), $urandom());
    // fill past full, then drain past empty
    repeat (DEPTH + 6) add_item(ACT_INSERT, $urandom(), rand_prio());
    repeat (DEPTH + 6) add_item(ACT_REMOVE, $urandom(), $urandom());
    // random phases leaning toward filling, draining or balanced
    while (pending_q.size() < 1150) begin
      kind = $urandom_range(0, 2);
      len  = $urandom_range(20, 100);
      repeat (len) add_random(kind == 0 ? 85 : (kind == 1 ? 15 : 50));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() > 0 || in_valid || snapshot_q.size() > 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("sorted_priority_queue regression: pass");
    end else begin
      $display("sorted_priority_queue regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("sorted_priority_queue regression: fail");
    $finish;
  end

endmodule
